FILE: sv/scpq_pkg.sv
package scpq_pkg;

   localparam int CSR_W = 5;
   localparam int CNT_W = 5;
   localparam int ERR_W = 2;
   localparam int CAP_DEFAULT = 16;

   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_REMOVE = 1'b1;

   localparam logic [ERR_W-1:0] ERR_OK    = 2'd0;
   localparam logic [ERR_W-1:0] ERR_FULL  = 2'd1;
   localparam logic [ERR_W-1:0] ERR_EMPTY = 2'd2;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_BUBBLE,
      ST_FINISH
   } state_type;

endpackage

FILE: sv/scpq_req_if.sv
interface scpq_req_if #(
   parameter int PRIO_BITS  = 8,
   parameter int VALUE_BITS = 16
) ();
   logic                  valid;
   logic                  ready;
   logic                  opcode;
   logic [PRIO_BITS-1:0]  item_priority;
   logic [VALUE_BITS-1:0] item_value;

   modport source (output valid, output opcode, output item_priority, output item_value,
                   input ready);
   modport sink (input valid, input opcode, input item_priority, input item_value,
                 output ready);
endinterface

FILE: sv/scpq_rsp_if.sv
interface scpq_rsp_if #(
   parameter int PRIO_BITS  = 8,
   parameter int VALUE_BITS = 16
) ();
   logic                              valid;
   logic                              ready;
   logic                              out_valid;
   logic [PRIO_BITS-1:0]              out_priority;
   logic [VALUE_BITS-1:0]             out_value;
   logic [scpq_pkg::ERR_W-1:0]        error_code;
   logic [scpq_pkg::CNT_W-1:0]        entry_count;
   logic                              is_empty;
   logic                              is_full;

   modport source (output valid, output out_valid, output out_priority, output out_value,
                   output error_code, output entry_count, output is_empty,
                   output is_full, input ready);
   modport sink (input valid, input out_valid, input out_priority, input out_value,
                 input error_code, input entry_count, input is_empty, input is_full,
                 output ready);
endinterface

FILE: sv/scpq_ram.sv
module scpq_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

FILE: sv/sorted_circular_priority_queue.sv
// Sorted circular priority queue.
// req_ch carries one operation per transfer: opcode insert with item_priority
// and item_value, or opcode remove. rsp_ch returns exactly one result per
// operation, in order: the removed entry (out_valid set) or zeros, an error
// code (insert while full, remove while empty), and the count, empty and
// full flags after the operation. csr_wr_en / csr_wr_data set the number of
// slots in use (0 reads as 1, above DEPTH as DEPTH) and empty the queue.
// Entries live in one RAM with a registered read. An insert walks
// from the tail toward the head, one read-compare-write per slot. One
// operation is in flight at a time; req_ch.ready is high only between
// operations. The result sits in an output register; when rsp_ch stalls,
// the next operation is still taken and finishes up to its result, which
// then waits for the register. Reset empties the queue, sets 16 slots (or
// DEPTH if smaller) and clears the output valid flag.
module sorted_circular_priority_queue #(
   parameter int DEPTH      = 16,
   parameter int PRIO_BITS  = 8,
   parameter int VALUE_BITS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   scpq_req_if.sink                      req_ch,
   scpq_rsp_if.source                    rsp_ch,
   input  logic                          csr_wr_en,
   input  logic [scpq_pkg::CSR_W-1:0]    csr_wr_data
);

   localparam int SLOT_W = $clog2(DEPTH + 1);
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int ENTRY_W = PRIO_BITS + VALUE_BITS;
   localparam int CAP_RESET = (scpq_pkg::CAP_DEFAULT > DEPTH) ? DEPTH :
                              scpq_pkg::CAP_DEFAULT;
   localparam logic [SLOT_W-1:0] SLOT_ZERO = '0;
   localparam logic [SLOT_W-1:0] SLOT_ONE = SLOT_W'(1);

   typedef struct packed {
      logic                       out_valid;
      logic [PRIO_BITS-1:0]       out_priority;
      logic [VALUE_BITS-1:0]      out_value;
      logic [scpq_pkg::ERR_W-1:0] error_code;
      logic [SLOT_W-1:0]          entry_count;
      logic                       is_empty;
      logic                       is_full;
   } result_type;

   scpq_pkg::state_type state_ff, state_in;
   logic [SLOT_W-1:0]     head_ff, head_in;
   logic [SLOT_W-1:0]     tail_ff, tail_in;
   logic [SLOT_W-1:0]     count_ff, count_in;
   logic [SLOT_W-1:0]     cap_ff, cap_in;
   logic [SLOT_W-1:0]     slot_ff, slot_in;
   logic [PRIO_BITS-1:0]  new_prio_ff, new_prio_in;
   logic [VALUE_BITS-1:0] new_value_ff, new_value_in;
   result_type            res_ff, res_in;
   result_type            rsp_data_ff, rsp_data_in;
   logic                  rsp_valid_ff, rsp_valid_in;

   logic                  accept;
   logic                  is_insert;
   logic                  full_now;
   logic                  empty_now;
   logic                  move;
   logic                  rsp_free;
   logic [SLOT_W-1:0]     prev_slot;
   logic [SLOT_W-1:0]     prev2_slot;
   logic [SLOT_W-1:0]     next_tail;
   logic [SLOT_W-1:0]     tail_prev;
   logic [SLOT_W-1:0]     next_head;
   logic [SLOT_W-1:0]     count_inc;
   logic [SLOT_W-1:0]     count_dec;
   logic [SLOT_W-1:0]     cap_wr;
   logic [PRIO_BITS-1:0]  rd_prio;
   logic [VALUE_BITS-1:0] rd_value;

   logic                  ram_wr_en;
   logic [ADDR_W-1:0]     ram_wr_addr;
   logic [ENTRY_W-1:0]    ram_wr_data;
   logic                  ram_rd_en;
   logic [ADDR_W-1:0]     ram_rd_addr;
   logic [ENTRY_W-1:0]    ram_rd_data;

   scpq_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign accept    = req_ch.valid && req_ch.ready;
   assign is_insert = (req_ch.opcode == scpq_pkg::OP_INSERT);
   assign full_now  = (count_ff == cap_ff);
   assign empty_now = (count_ff == SLOT_ZERO);
   assign rsp_free  = !rsp_valid_ff || rsp_ch.ready;

   assign rd_prio  = ram_rd_data[ENTRY_W-1 -: PRIO_BITS];
   assign rd_value = ram_rd_data[VALUE_BITS-1:0];

   assign prev_slot  = (slot_ff == SLOT_ONE) ? cap_ff : slot_ff - SLOT_ONE;
   assign prev2_slot = (prev_slot == SLOT_ONE) ? cap_ff : prev_slot - SLOT_ONE;
   assign next_tail  = (empty_now || tail_ff == cap_ff) ? SLOT_ONE : tail_ff + SLOT_ONE;
   assign tail_prev  = (next_tail == SLOT_ONE) ? cap_ff : next_tail - SLOT_ONE;
   assign next_head  = (head_ff == cap_ff) ? SLOT_ONE : head_ff + SLOT_ONE;
   assign count_inc  = count_ff + SLOT_ONE;
   assign count_dec  = count_ff - SLOT_ONE;
   assign move       = (slot_ff != head_ff) && (new_prio_ff > rd_prio);

   always_comb begin
      if (csr_wr_data == '0) begin
         cap_wr = SLOT_ONE;
      end else if (32'(csr_wr_data) > DEPTH) begin
         cap_wr = SLOT_W'(DEPTH);
      end else begin
         cap_wr = SLOT_W'(csr_wr_data);
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         scpq_pkg::ST_IDLE: begin
            if (accept) begin
               if (is_insert) begin
                  state_in = full_now ? scpq_pkg::ST_FINISH : scpq_pkg::ST_BUBBLE;
               end else begin
                  state_in = empty_now ? scpq_pkg::ST_FINISH : scpq_pkg::ST_READ;
               end
            end
         end
         scpq_pkg::ST_READ: begin
            state_in = scpq_pkg::ST_FINISH;
         end
         scpq_pkg::ST_BUBBLE: begin
            if (!move) begin
               state_in = scpq_pkg::ST_FINISH;
            end
         end
         scpq_pkg::ST_FINISH: begin
            if (rsp_free) begin
               state_in = scpq_pkg::ST_IDLE;
            end
         end
         default: state_in = scpq_pkg::ST_IDLE;
      endcase
   end

   // datapath and RAM control
   always_comb begin
      head_in      = head_ff;
      tail_in      = tail_ff;
      count_in     = count_ff;
      cap_in       = cap_ff;
      slot_in      = slot_ff;
      new_prio_in  = new_prio_ff;
      new_value_in = new_value_ff;
      res_in       = res_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      ram_wr_en    = 1'b0;
      ram_wr_addr  = ADDR_W'(slot_ff - SLOT_ONE);
      ram_wr_data  = {new_prio_ff, new_value_ff};
      ram_rd_en    = 1'b0;
      ram_rd_addr  = ADDR_W'(prev2_slot - SLOT_ONE);

      unique case (state_ff)
         scpq_pkg::ST_IDLE: begin
            if (accept) begin
               res_in.out_valid    = 1'b0;
               res_in.out_priority = '0;
               res_in.out_value    = '0;
               res_in.error_code   = scpq_pkg::ERR_OK;
               res_in.entry_count  = count_ff;
               res_in.is_empty     = empty_now;
               res_in.is_full      = full_now;
               if (is_insert) begin
                  if (full_now) begin
                     res_in.error_code = scpq_pkg::ERR_FULL;
                  end else begin
                     head_in      = empty_now ? SLOT_ONE : head_ff;
                     tail_in      = next_tail;
                     count_in     = count_inc;
                     slot_in      = next_tail;
                     new_prio_in  = req_ch.item_priority;
                     new_value_in = req_ch.item_value;
                     ram_rd_en    = 1'b1;
                     ram_rd_addr  = ADDR_W'(tail_prev - SLOT_ONE);
                     res_in.entry_count = count_inc;
                     res_in.is_empty    = 1'b0;
                     res_in.is_full     = (count_inc == cap_ff);
                  end
               end else begin
                  if (empty_now) begin
                     res_in.error_code = scpq_pkg::ERR_EMPTY;
                  end else begin
                     ram_rd_en   = 1'b1;
                     ram_rd_addr = ADDR_W'(head_ff - SLOT_ONE);
                     count_in    = count_dec;
                     if (count_ff == SLOT_ONE) begin
                        head_in = SLOT_ZERO;
                        tail_in = SLOT_ZERO;
                     end else begin
                        head_in = next_head;
                     end
                     res_in.entry_count = count_dec;
                     res_in.is_empty    = (count_dec == SLOT_ZERO);
                     res_in.is_full     = (count_dec == cap_ff);
                  end
               end
            end else if (csr_wr_en) begin
               cap_in   = cap_wr;
               head_in  = SLOT_ZERO;
               tail_in  = SLOT_ZERO;
               count_in = SLOT_ZERO;
            end
         end
         scpq_pkg::ST_READ: begin
            res_in.out_valid    = 1'b1;
            res_in.out_priority = rd_prio;
            res_in.out_value    = rd_value;
         end
         scpq_pkg::ST_BUBBLE: begin
            ram_wr_en = 1'b1;
            if (move) begin
               // shift the lower-priority neighbor back one slot
               ram_wr_data = ram_rd_data;
               slot_in     = prev_slot;
               ram_rd_en   = 1'b1;
            end
         end
         scpq_pkg::ST_FINISH: begin
            if (rsp_free) begin
               rsp_data_in  = res_ff;
               rsp_valid_in = 1'b1;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= scpq_pkg::ST_IDLE;
         head_ff      <= SLOT_ZERO;
         tail_ff      <= SLOT_ZERO;
         count_ff     <= SLOT_ZERO;
         cap_ff       <= SLOT_W'(CAP_RESET);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
         cap_ff       <= cap_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      slot_ff      <= slot_in;
      new_prio_ff  <= new_prio_in;
      new_value_ff <= new_value_in;
      res_ff       <= res_in;
      rsp_data_ff  <= rsp_data_in;
   end

   assign req_ch.ready        = (state_ff == scpq_pkg::ST_IDLE);
   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.out_valid    = rsp_data_ff.out_valid;
   assign rsp_ch.out_priority = rsp_data_ff.out_priority;
   assign rsp_ch.out_value    = rsp_data_ff.out_value;
   assign rsp_ch.error_code   = rsp_data_ff.error_code;
   assign rsp_ch.entry_count  = scpq_pkg::CNT_W'(rsp_data_ff.entry_count);
   assign rsp_ch.is_empty     = rsp_data_ff.is_empty;
   assign rsp_ch.is_full      = rsp_data_ff.is_full;

`ifndef ASSERT_OFF
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= cap_ff)
      else $error("entry count above capacity");

   a_head_empty: assert property (@(posedge clock) disable iff (reset)
      (count_ff == SLOT_ZERO) == (head_ff == SLOT_ZERO))
      else $error("head slot disagrees with entry count");

   a_bubble_slot: assert property (@(posedge clock) disable iff (reset)
      state_ff == scpq_pkg::ST_BUBBLE |-> slot_ff != SLOT_ZERO && slot_ff <= cap_ff)
      else $error("insert walk left the slot range");

   a_finish_load: assert property (@(posedge clock) disable iff (reset)
      state_ff == scpq_pkg::ST_FINISH && rsp_free |=> rsp_ch.valid)
      else $error("finished result not presented");
`endif

endmodule

FILE: tb/sv/tb.sv
`timescale 1ns / 100ps

module tb;

   localparam int DEPTH        = 16;
   localparam int PRIO_BITS    = 8;
   localparam int VALUE_BITS   = 16;
   localparam int DRAIN_CYCLES = 24;
   localparam int LIMIT_CYCLES = 400000;

   typedef struct packed {
      logic                            out_valid;
      logic [PRIO_BITS-1:0]            out_priority;
      logic [VALUE_BITS-1:0]           out_value;
      logic [scpq_pkg::ERR_W-1:0]      error_code;
      logic [scpq_pkg::CNT_W-1:0]      entry_count;
      logic                            is_empty;
      logic                            is_full;
   } reply_type;

   logic                       clock;
   logic                       reset;
   logic                       csr_wr_en;
   logic [scpq_pkg::CSR_W-1:0] csr_wr_data;

   scpq_req_if #(.PRIO_BITS(PRIO_BITS), .VALUE_BITS(VALUE_BITS)) req_ch ();
   scpq_rsp_if #(.PRIO_BITS(PRIO_BITS), .VALUE_BITS(VALUE_BITS)) rsp_ch ();

   sorted_circular_priority_queue #(
      .DEPTH      (DEPTH),
      .PRIO_BITS  (PRIO_BITS),
      .VALUE_BITS (VALUE_BITS)
   ) i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // queue image: slots 1..ring_cap, head/tail 0 when empty
   logic [PRIO_BITS-1:0]  slot_prio [1:DEPTH];
   logic [VALUE_BITS-1:0] slot_value [1:DEPTH];
   int                    ring_head;
   int                    ring_tail;
   int                    ring_cap;

   reply_type due_replies [$];
   int        fault_count;
   int        cycle_count;
   int        hold_off_cycles;
   bit        idle_on;

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   function automatic int held_entries();
      if (ring_head == 0 && ring_tail == 0) begin
         return 0;
      end
      return ((ring_tail + ring_cap - ring_head) % ring_cap) + 1;
   endfunction

   function automatic reply_type predict_queue_op(input logic op,
                                                  input logic [PRIO_BITS-1:0] pr,
                                                  input logic [VALUE_BITS-1:0] val);
      reply_type             r;
      int                    n;
      int                    i;
      int                    prev;
      logic [PRIO_BITS-1:0]  tp;
      logic [VALUE_BITS-1:0] tv;
      r = '0;
      n = held_entries();
      if (op == scpq_pkg::OP_INSERT) begin
         if (n >= ring_cap) begin
            r.error_code = scpq_pkg::ERR_FULL;
         end else begin
            if (n == 0) begin
               ring_head = 1;
               ring_tail = 0;
            end
            ring_tail = (ring_tail % ring_cap) + 1;
            slot_prio[ring_tail] = pr;
            slot_value[ring_tail] = val;
            i = ring_tail;
            while (i != ring_head) begin
               prev = (i == 1) ? ring_cap : i - 1;
               if (slot_prio[i] <= slot_prio[prev]) begin
                  break;
               end
               tp = slot_prio[i];
               tv = slot_value[i];
               slot_prio[i] = slot_prio[prev];
               slot_value[i] = slot_value[prev];
               slot_prio[prev] = tp;
               slot_value[prev] = tv;
               i = prev;
            end
         end
      end else begin
         if (n == 0) begin
            r.error_code = scpq_pkg::ERR_EMPTY;
         end else begin
            r.out_valid = 1'b1;
            r.out_priority = slot_prio[ring_head];
            r.out_value = slot_value[ring_head];
            if (n == 1) begin
               ring_head = 0;
               ring_tail = 0;
            end else begin
               ring_head = (ring_head % ring_cap) + 1;
            end
         end
      end
      n = held_entries();
      r.entry_count = scpq_pkg::CNT_W'(n);
      r.is_empty = (n == 0);
      r.is_full = (n == ring_cap);
      return r;
   endfunction

   task automatic send_op(input logic op, input logic [PRIO_BITS-1:0] pr,
                          input logic [VALUE_BITS-1:0] val);
      int gap;
      gap = 0;
      if (idle_on && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 5);
      end
      @(negedge clock);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.opcode <= op;
      req_ch.item_priority <= pr;
      req_ch.item_value <= val;
      do @(posedge clock); while (!req_ch.ready);
      due_replies.push_back(predict_queue_op(op, pr, val));
   endtask

   task automatic wait_drain();
      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (due_replies.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic set_capacity(input logic [scpq_pkg::CSR_W-1:0] c);
      wait_drain();
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= c;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      ring_cap = (c == 0) ? 1 : ((c > DEPTH) ? DEPTH : int'(c));
      ring_head = 0;
      ring_tail = 0;
   endtask

   task automatic run_burst(input int n, input int ins_pct);
      int                   k;
      logic                 op;
      logic [PRIO_BITS-1:0] pr;
      for (k = 0; k < n; k++) begin
         op = ($urandom_range(0, 99) < ins_pct) ? scpq_pkg::OP_INSERT : scpq_pkg::OP_REMOVE;
         case ($urandom_range(0, 3))
            0: pr = PRIO_BITS'($urandom_range(0, 3));
            1: pr = ($urandom_range(0, 1) == 1) ? '1 : '0;
            default: pr = PRIO_BITS'($urandom());
         endcase
         send_op(op, pr, VALUE_BITS'($urandom()));
      end
   endtask

   task automatic test_directed_cases();
      send_op(scpq_pkg::OP_REMOVE, 8'h00, 16'h0000);
      send_op(scpq_pkg::OP_INSERT, 8'h00, 16'h0000);
      send_op(scpq_pkg::OP_INSERT, 8'hFF, 16'hFFFF);
      send_op(scpq_pkg::OP_INSERT, 8'h80, 16'h1234);
      send_op(scpq_pkg::OP_INSERT, 8'h80, 16'h5678);
      send_op(scpq_pkg::OP_INSERT, 8'h80, 16'h9ABC);
      send_op(scpq_pkg::OP_INSERT, 8'h00, 16'hAAAA);
      repeat (7) send_op(scpq_pkg::OP_REMOVE, 8'hFF, 16'hFFFF);
      set_capacity(5'd2);
      send_op(scpq_pkg::OP_INSERT, 8'h10, 16'h1111);
      send_op(scpq_pkg::OP_INSERT, 8'h20, 16'h2222);
      send_op(scpq_pkg::OP_INSERT, 8'h30, 16'h3333);
      // write while holding entries: queue empties
      set_capacity(5'd0);
      send_op(scpq_pkg::OP_REMOVE, 8'h55, 16'h5555);
      send_op(scpq_pkg::OP_INSERT, 8'h07, 16'h7777);
      send_op(scpq_pkg::OP_INSERT, 8'h08, 16'h8888);
      send_op(scpq_pkg::OP_REMOVE, 8'h00, 16'h0000);
      set_capacity(5'd31);
   endtask

   task automatic test_capacity_settings();
      logic [scpq_pkg::CSR_W-1:0] caps [6];
      int                         k;
      caps = '{5'd16, 5'd1, 5'd17, 5'd2, 5'd3, 5'd15};
      for (k = 0; k < 6; k++) begin
         set_capacity(caps[k]);
         run_burst(30, 80);
         run_burst(30, 30);
      end
   endtask

   task automatic test_output_holdoff();
      set_capacity(5'd8);
      hold_off_cycles = 120;
      run_burst(24, 70);
      wait_drain();
   endtask

   task automatic test_random_traffic();
      int k;
      for (k = 0; k < 12; k++) begin
         if ($urandom_range(0, 2) == 0) begin
            set_capacity(scpq_pkg::CSR_W'($urandom_range(0, 31)));
         end
         idle_on = ($urandom_range(0, 4) != 0);
         run_burst(45, 70);
         run_burst(45, 35);
      end
      idle_on = 1'b1;
   endtask

   task automatic test_back_to_back();
      set_capacity(5'd16);
      idle_on = 1'b0;
      run_burst(100, 65);
      run_burst(100, 40);
   endtask

   initial begin
      rsp_ch.ready = 1'b0;
      forever begin
         int stall_left;
         @(negedge clock);
         if (hold_off_cycles > 0) begin
            rsp_ch.ready <= 1'b0;
            hold_off_cycles--;
         end else if (stall_left > 0) begin
            rsp_ch.ready <= 1'b0;
            stall_left--;
         end else if (idle_on && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(1, 5) - 1;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      reply_type got;
      reply_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         got.out_valid = rsp_ch.out_valid;
         got.out_priority = rsp_ch.out_priority;
         got.out_value = rsp_ch.out_value;
         got.error_code = rsp_ch.error_code;
         got.entry_count = rsp_ch.entry_count;
         got.is_empty = rsp_ch.is_empty;
         got.is_full = rsp_ch.is_full;
         if (due_replies.size() == 0) begin
            if (fault_count < 10) begin
               $display("unexpected result transfer at cycle %0d", cycle_count);
            end
            fault_count++;
         end else begin
            want = due_replies.pop_front();
            if (got !== want) begin
               if (fault_count < 10) begin
                  $display("mismatch at cycle %0d: expected v=%b p=%h d=%h e=%0d n=%0d",
                           cycle_count, want.out_valid, want.out_priority, want.out_value,
                           want.error_code, want.entry_count);
                  $display("  expected em=%b fu=%b", want.is_empty, want.is_full);
                  $display("  actual v=%b p=%h d=%h e=%0d n=%0d em=%b fu=%b",
                           got.out_valid, got.out_priority, got.out_value, got.error_code,
                           got.entry_count, got.is_empty, got.is_full);
               end
               fault_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("[sorted_circular_priority_queue] ERROR");
         $finish;
      end
   end

   initial begin
      reset = 1'b1;
      csr_wr_en = 1'b0;
      csr_wr_data = '0;
      req_ch.valid = 1'b0;
      req_ch.opcode = scpq_pkg::OP_INSERT;
      req_ch.item_priority = '0;
      req_ch.item_value = '0;
      fault_count = 0;
      cycle_count = 0;
      hold_off_cycles = 0;
      idle_on = 1'b1;
      ring_head = 0;
      ring_tail = 0;
      ring_cap = (scpq_pkg::CAP_DEFAULT > DEPTH) ? DEPTH : scpq_pkg::CAP_DEFAULT;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed_cases();
      test_capacity_settings();
      test_output_holdoff();
      test_random_traffic();
      test_back_to_back();
      wait_drain();

      if (fault_count == 0 && due_replies.size() == 0) begin
         $display("[sorted_circular_priority_queue] OK");
      end else begin
         $display("[sorted_circular_priority_queue] ERROR");
      end
      $finish;
   end

endmodule
